/* rtl/core/accel_gesture_detector_defines.svh */
// Assertion macros used by the gesture detector checker.
`ifndef ACCEL_GESTURE_DETECTOR_DEFINES_SVH
`define ACCEL_GESTURE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AGD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/agd_pkg.sv */
// Package with types, codes and helper functions of the gesture detector.
`timescale 1ns / 1ps

package agd_pkg;

    localparam int ACC_W   = 16;
    localparam int SUM_W   = 24;
    localparam int DB_W    = 15;
    localparam int TL_W    = 23;
    localparam int TIME_W  = 32;
    localparam int ITEM_W  = 8;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 4;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 16;

    localparam int AGD_MAX_ITEM = 7;

    localparam logic [DB_W-1:0]   DEAD_BAND_RST   = 15'd128;
    localparam logic [TL_W-1:0]   TRIG_LEVEL_RST  = 23'd15360;
    localparam logic [TIME_W-1:0] TRIG_HOLD_RST   = 32'd1000000;
    localparam logic [TIME_W-1:0] COOLDOWN_RST    = 32'd500000;

    typedef enum logic [1:0] {
        REG_DEAD_BAND  = 2'd0,
        REG_TRIG_LEVEL = 2'd1,
        REG_TRIG_HOLD  = 2'd2,
        REG_COOLDOWN   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        DIR_RIGHT = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_PUSH  = 3'd2,
        DIR_PULL  = 3'd3,
        DIR_UP    = 3'd4,
        DIR_DOWN  = 3'd5
    } t_dir;

    typedef enum logic [1:0] {
        CMD_NONE        = 2'd0,
        CMD_STEP_LEFT   = 2'd1,
        CMD_STEP_RIGHT  = 2'd2,
        CMD_LOCK_CHANGE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic neg;
    } t_cross;

    // Adds a sample outside the dead band with saturation, else halves toward zero.
    function automatic logic [SUM_W-1:0] f_accumulate(
        input logic [SUM_W-1:0] sum,
        input logic [ACC_W-1:0] a,
        input logic [DB_W-1:0]  db
    );
        logic [ACC_W:0] mag;
        logic [SUM_W:0] s;
        logic [SUM_W:0] rnd;
        logic [SUM_W-1:0] res;
        mag = a[ACC_W-1] ? ((ACC_W+1)'(0) - {1'b1, a}) : {1'b0, a};
        s   = {sum[SUM_W-1], sum} + {{(SUM_W+1-ACC_W){a[ACC_W-1]}}, a};
        rnd = {sum[SUM_W-1], sum} + {{SUM_W{1'b0}}, sum[SUM_W-1]};
        if (mag > {{(ACC_W+1-DB_W){1'b0}}, db}) begin
            if (s[SUM_W] != s[SUM_W-1]) begin
                res = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                res = s[SUM_W-1:0];
            end
        end else begin
            res = rnd[SUM_W:1];
        end
        return res;
    endfunction

    // Compares an accumulator against plus and minus the trigger level.
    function automatic t_cross f_crossing(
        input logic [SUM_W-1:0] sum,
        input logic [TL_W-1:0]  tl
    );
        logic signed [SUM_W:0] st;
        logic signed [SUM_W:0] tp;
        t_cross c;
        st = $signed({sum[SUM_W-1], sum});
        tp = $signed({{(SUM_W+1-TL_W){1'b0}}, tl});
        c.hit = 1'b0;
        c.neg = 1'b0;
        if (st >= tp) begin
            c.hit = 1'b1;
        end else if (st <= -tp) begin
            c.hit = 1'b1;
            c.neg = 1'b1;
        end
        return c;
    endfunction

endpackage

/* rtl/core/accel_gesture_detector.sv */
// Top level of the accelerometer gesture detector.
`timescale 1ns / 1ps

// Takes one timestamped three-axis sample per item and emits one result item each time a
// gesture fires: direction, control command, selected item index and lock flag. The block
// accepts one item per clock cycle unless back pressure stalls it. That rate is set by the
// combinational update of the accumulators, trigger check and control state, which sits
// between the input register and the result register. Back pressure on the output stalls
// the input only while a result is waiting. Registers are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
module accel_gesture_detector
    import agd_pkg::*;
#(
    parameter int MAX_ITEM = AGD_MAX_ITEM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], time_us [79:48]
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // gesture_dir [2:0], control_cmd [4:3], item_index [12:5], is_locked [13], zeros [15:14]
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    logic [DB_W-1:0]   r_dead_band;
    logic [TL_W-1:0]   r_trig_level;
    logic [TIME_W-1:0] r_trig_hold;
    logic [TIME_W-1:0] r_cooldown;

    logic              r_in_valid;
    logic [ACC_W-1:0]  r_ax;
    logic [ACC_W-1:0]  r_ay;
    logic [ACC_W-1:0]  r_az;
    logic [TIME_W-1:0] r_time;

    logic [SUM_W-1:0]  r_sum_x;
    logic [SUM_W-1:0]  r_sum_y;
    logic [SUM_W-1:0]  r_sum_z;
    logic [TIME_W-1:0] r_last_trig;
    logic [TIME_W-1:0] r_last_gest;
    logic              r_lock;
    logic [ITEM_W-1:0] r_item;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [SUM_W-1:0]  n_sum_x;
    logic [SUM_W-1:0]  n_sum_y;
    logic [SUM_W-1:0]  n_sum_z;
    logic              n_lock;
    logic [ITEM_W-1:0] n_item;

    t_cross            cx;
    t_cross            cy;
    t_cross            cz;
    t_dir              dir;
    t_cmd              cmd;
    logic              fire;
    logic              cool;
    logic              out_free;
    logic              advance;
    logic              cfg_wr;
    logic [ITEM_W-1:0] max_item;

    assign max_item = ITEM_W'(MAX_ITEM);
    assign out_free = !r_out_valid || m_axis_tready;
    assign advance  = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_DEAD_BAND:  prdata = {{(CFG_W-DB_W){1'b0}}, r_dead_band};
            REG_TRIG_LEVEL: prdata = {{(CFG_W-TL_W){1'b0}}, r_trig_level};
            REG_TRIG_HOLD:  prdata = r_trig_hold;
            REG_COOLDOWN:   prdata = r_cooldown;
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        n_sum_x = f_accumulate(r_sum_x, r_ax, r_dead_band);
        n_sum_y = f_accumulate(r_sum_y, r_ay, r_dead_band);
        n_sum_z = f_accumulate(r_sum_z, r_az, r_dead_band);
        cx = f_crossing(n_sum_x, r_trig_level);
        cy = f_crossing(n_sum_y, r_trig_level);
        cz = f_crossing(n_sum_z, r_trig_level);
        fire = (cx.hit || cy.hit || cz.hit) && ((r_time - r_last_trig) > r_trig_hold);
        cool = (r_time - r_last_gest) > r_cooldown;

        dir = DIR_RIGHT;
        if (cx.hit) begin
            dir = cx.neg ? DIR_LEFT : DIR_RIGHT;
        end
        if (cy.hit) begin
            dir = cy.neg ? DIR_PULL : DIR_PUSH;
        end
        if (cz.hit) begin
            dir = cz.neg ? DIR_DOWN : DIR_UP;
        end

        cmd    = CMD_NONE;
        n_lock = r_lock;
        n_item = r_item;
        case (dir)
            DIR_LEFT: begin
                if (r_lock && cool) begin
                    if (r_item != '0) begin
                        n_item = r_item - 1'b1;
                    end
                    cmd = CMD_STEP_LEFT;
                end
            end
            DIR_RIGHT: begin
                if (r_item <= max_item && r_lock && cool) begin
                    if (r_item < max_item) begin
                        n_item = r_item + 1'b1;
                    end
                    cmd = CMD_STEP_RIGHT;
                end
            end
            DIR_PULL: begin
                if (cool && r_lock) begin
                    n_lock = 1'b0;
                    cmd = CMD_LOCK_CHANGE;
                end
            end
            DIR_PUSH: begin
                if (cool && !r_lock) begin
                    n_lock = 1'b1;
                    cmd = CMD_LOCK_CHANGE;
                end
            end
            default: begin
                cmd = CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_band  <= DEAD_BAND_RST;
            r_trig_level <= TRIG_LEVEL_RST;
            r_trig_hold  <= TRIG_HOLD_RST;
            r_cooldown   <= COOLDOWN_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_DEAD_BAND:  r_dead_band  <= pwdata[DB_W-1:0];
                REG_TRIG_LEVEL: r_trig_level <= pwdata[TL_W-1:0];
                REG_TRIG_HOLD:  r_trig_hold  <= pwdata;
                REG_COOLDOWN:   r_cooldown   <= pwdata;
                default:        r_cooldown   <= r_cooldown;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_ax   <= s_axis_tdata[15:0];
            r_ay   <= s_axis_tdata[31:16];
            r_az   <= s_axis_tdata[47:32];
            r_time <= s_axis_tdata[79:48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_last_trig <= '0;
            r_last_gest <= '0;
            r_lock      <= 1'b0;
            r_item      <= '0;
        end else if (advance) begin
            r_sum_x <= (fire && cx.hit) ? '0 : n_sum_x;
            r_sum_y <= (fire && cy.hit) ? '0 : n_sum_y;
            r_sum_z <= (fire && cz.hit) ? '0 : n_sum_z;
            if (fire) begin
                r_last_trig <= r_time;
                r_last_gest <= r_time;
                r_lock      <= n_lock;
                r_item      <= n_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && fire) begin
            r_out_data <= {2'b00, n_lock, n_item, cmd, dir};
        end
    end

endmodule

/* rtl/core/agd_checker.sv */
// Port-level checker of the gesture detector and its bind to the top level.
`timescale 1ns / 1ps
`include "accel_gesture_detector_defines.svh"

module agd_checker
    import agd_pkg::*;
#(
    parameter int MAX_ITEM = AGD_MAX_ITEM
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] i_m_tdata
);

    t_dir              dir;
    t_cmd              cmd;
    logic [ITEM_W-1:0] item;
    logic              locked;

    assign dir    = t_dir'(i_m_tdata[2:0]);
    assign cmd    = t_cmd'(i_m_tdata[4:3]);
    assign item   = i_m_tdata[12:5];
    assign locked = i_m_tdata[13];

    // A stalled result keeps its contents until it is taken.
    `AGD_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "result changed while stalled")

    // Item steps only happen while locked and match the fired direction.
    `AGD_ASSERT_NOW(a_step_dir, i_m_tvalid && (cmd == CMD_STEP_LEFT || cmd == CMD_STEP_RIGHT), locked && ((cmd == CMD_STEP_LEFT && dir == DIR_LEFT) || (cmd == CMD_STEP_RIGHT && dir == DIR_RIGHT)), "item step inconsistent with direction or lock")

    // A lock change ends locked after a push and unlocked after a pull.
    `AGD_ASSERT_NOW(a_lock_dir, i_m_tvalid && cmd == CMD_LOCK_CHANGE, (dir == DIR_PUSH && locked) || (dir == DIR_PULL && !locked), "lock change inconsistent with direction")

    // The selected item never passes the top index.
    `AGD_ASSERT_NOW(a_item_max, i_m_tvalid, item <= ITEM_W'(MAX_ITEM), "item index above maximum")

endmodule

bind accel_gesture_detector agd_checker #(
    .MAX_ITEM (MAX_ITEM)
) u_agd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
